@@ hdl/priority_round_robin_thread_scheduler_macros.svh @@
// Assertion macros for the thread scheduler block.
// Included by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef PRIORITY_ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH
`define PRIORITY_ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every clock edge outside reset.
`define PRT_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");
// Next-cycle implication.
`define PRT_ASSERT_NX(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");
`else
`define PRT_ASSERT(lbl, ante, cons)
`define PRT_ASSERT_NX(lbl, ante, cons)
`endif
`endif

@@ hdl/prt_pkg.sv @@
// Shared types, constants and helpers of the thread scheduler.
// No dependencies; used by the top level.
package prt_pkg;

  localparam int MAX_THREADS = 64;
  localparam int NUM_LEVELS  = 32;
  localparam int THR_W       = $clog2(MAX_THREADS);
  localparam int PTR_W       = THR_W + 1;
  localparam int LVL_W       = $clog2(NUM_LEVELS);
  localparam int SPAN_W      = 3;
  localparam int TIME_W      = 32;
  localparam int FUNC_W      = 3;
  localparam int WOKEN_W     = 7;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [SPAN_W-1:0] SPAN_LIMIT_RST = 3'd5;

  typedef logic [PTR_W-1:0] ptr_t;
  // A pointer with its top bit set is null.
  localparam ptr_t NIL = ptr_t'(1) << THR_W;

  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FN_READY  = 3'd0,
    FN_PAUSE  = 3'd1,
    FN_SLEEP  = 3'd2,
    FN_SCHED  = 3'd3,
    FN_DELETE = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    MEMB_NONE  = 2'd0,
    MEMB_RUN   = 2'd1,
    MEMB_SLEEP = 2'd2
  } memb_e;

  typedef struct packed {
    logic [LVL_W-1:0]  level;
    logic [SPAN_W-1:0] span;
    memb_e             memb;
    logic [TIME_W-1:0] wake;
  } info_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MR_RD, S_MR_CK, S_APP, S_APP2,
    S_PA_RD, S_PA_CK, S_PA_UL, S_PA_MK, S_SU,
    S_SW_ST, S_SW_RD, S_SW_CK, S_SW_IN, S_SW_LK,
    S_WK_RD, S_WK_CK, S_SC_PICK, S_SC_RD, S_SC_CK, S_SC_RO,
    S_SC_END, S_CL_RD, S_CL_WR, S_FIN
  } state_e;

  function automatic logic is_nil(input ptr_t p);
    return p[THR_W];
  endfunction

endpackage

@@ hdl/prt_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module prt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hdl/priority_round_robin_thread_scheduler.sv @@
// Multilevel priority round-robin thread scheduler, top level.
// Depends on prt_pkg, prt_ram and priority_round_robin_thread_scheduler_macros.svh.
//
// Usage:
// Operations arrive as items on the input channel (in_valid_i / in_ready_o) and
// every item yields exactly one result item on the output channel
// (out_valid_o / out_ready_i) that reports the running thread after the item.
// The block works on one item at a time; in_ready_o is high only while the
// sequencer is idle. Per-thread records and the link words live in three
// single-port-read RAMs, so every list step takes a read state and then a
// check/write state. A disabled schedule and unknown codes go straight to the
// final state. The sequencer returns to idle as the result is registered.
// Reset empties all run queues and the sleep list at once through valid bits
// on the thread records; no clearing pass is needed. Configuration must be
// written through the APB port only while no item is in flight; the block
// itself does not enforce this.
// When the receiver stalls, the result holds in the output register and the
// sequencer waits in its final state until the register frees up.
module priority_round_robin_thread_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [prt_pkg::FUNC_W-1:0]    func_i,
  input  logic [prt_pkg::THR_W-1:0]     thread_number_i,
  input  logic [prt_pkg::LVL_W-1:0]     priority_level_i,
  input  logic [prt_pkg::TIME_W-1:0]    sleep_duration_i,
  input  logic [prt_pkg::TIME_W-1:0]    now_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [prt_pkg::THR_W-1:0]     active_thread_o,
  output logic                          idle_o,
  output logic                          scheduled_o,
  output logic [prt_pkg::WOKEN_W-1:0]   woken_count_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prt_pkg::PADDR_W-1:0]   paddr,
  input  logic [prt_pkg::PDATA_W-1:0]   pwdata,
  output logic [prt_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import prt_pkg::*;
`include "priority_round_robin_thread_scheduler_macros.svh"

  state_e state_q, state_d;

  // Latched item fields.
  logic [FUNC_W-1:0] func_q, func_d;
  logic [TIME_W-1:0] end_q, end_d, now_q, now_d;
  // Thread under work and the level that the current step concerns.
  ptr_t              a_q, a_d;
  logic [LVL_W-1:0]  lq_q, lq_d;

  info_t rec_q, rec_d;
  ptr_t  tn_q, tn_d, tp_q, tp_d, cur_q, cur_d, prv_q, prv_d;
  ptr_t  chosen_q, chosen_d, running_q, running_d, shead_q, shead_d;
  logic [WOKEN_W-1:0]    woken_q, woken_d;
  logic [NUM_LEVELS-1:0] vis_q, vis_d, mask_q, mask_d;
  ptr_t head_q [NUM_LEVELS];
  ptr_t head_d [NUM_LEVELS];
  ptr_t tail_q [NUM_LEVELS];
  ptr_t tail_d [NUM_LEVELS];

  logic              enable_q;
  logic [SPAN_W-1:0] limit_q;

  logic               out_valid_q, out_valid_d, idle_q, idle_d, sched_q, sched_d;
  logic [THR_W-1:0]   cur_out_q, cur_out_d;
  logic [WOKEN_W-1:0] woken_out_q, woken_out_d;

  // RAM ports.
  logic [THR_W-1:0]        raddr;
  logic                    info_we, nx_we, pv_we;
  logic [THR_W-1:0]        info_waddr, nx_waddr, pv_waddr;
  info_t                   info_wdata, info_rd;
  logic [$bits(info_t)-1:0] info_rdata;
  ptr_t                    nx_wdata, pv_wdata, nx_rdata, pv_rdata;
  logic [MAX_THREADS-1:0]  valid_q;
  logic                    info_vld_q;

  prt_ram #(.WIDTH($bits(info_t)), .DEPTH(MAX_THREADS)) u_info_ram (
    .clk_i, .we_i(info_we), .waddr_i(info_waddr), .wdata_i(info_wdata),
    .raddr_i(raddr), .rdata_o(info_rdata)
  );
  prt_ram #(.WIDTH(PTR_W), .DEPTH(MAX_THREADS)) u_next_ram (
    .clk_i, .we_i(nx_we), .waddr_i(nx_waddr), .wdata_i(nx_wdata),
    .raddr_i(raddr), .rdata_o(nx_rdata)
  );
  prt_ram #(.WIDTH(PTR_W), .DEPTH(MAX_THREADS)) u_prev_ram (
    .clk_i, .we_i(pv_we), .waddr_i(pv_waddr), .wdata_i(pv_wdata),
    .raddr_i(raddr), .rdata_o(pv_rdata)
  );

  // A record never written since reset reads as all zero.
  assign info_rd = info_vld_q ? info_t'(info_rdata) : '0;

  // Non-empty levels and the most urgent one still to be visited.
  logic [NUM_LEVELS-1:0] nonempty, cand;
  logic [LVL_W-1:0]      pick;
  logic [SPAN_W:0]       span_inc;
  logic                  span_over;

  always_comb begin
    for (int l = 0; l < NUM_LEVELS; l++) begin
      nonempty[l] = !is_nil(head_q[l]);
    end
    cand = nonempty & vis_q;
    pick = '0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (cand[l]) begin
        pick = LVL_W'(l);
      end
    end
    span_inc  = {1'b0, info_rd.span} + (SPAN_W + 1)'(1);
    span_over = span_inc > {1'b0, limit_q};
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign active_thread_o  = cur_out_q;
  assign idle_o           = idle_q;
  assign scheduled_o      = sched_q;
  assign woken_count_o    = woken_out_q;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LIMIT) ? PDATA_W'(limit_q) : PDATA_W'(enable_q);

  always_comb begin
    state_d  = state_q;
    func_d   = func_q;
    end_d    = end_q;
    now_d    = now_q;
    a_d      = a_q;
    lq_d     = lq_q;
    rec_d    = rec_q;
    tn_d     = tn_q;
    tp_d     = tp_q;
    cur_d    = cur_q;
    prv_d    = prv_q;
    chosen_d = chosen_q;
    running_d = running_q;
    shead_d  = shead_q;
    woken_d  = woken_q;
    vis_d    = vis_q;
    mask_d   = mask_q;
    head_d   = head_q;
    tail_d   = tail_q;
    raddr    = a_q[THR_W-1:0];
    info_we    = 1'b0;
    info_waddr = a_q[THR_W-1:0];
    info_wdata = rec_q;
    nx_we    = 1'b0;
    nx_waddr = a_q[THR_W-1:0];
    nx_wdata = NIL;
    pv_we    = 1'b0;
    pv_waddr = a_q[THR_W-1:0];
    pv_wdata = NIL;
    out_valid_d = out_valid_q && !out_ready_i;
    cur_out_d   = cur_out_q;
    idle_d      = idle_q;
    sched_d     = sched_q;
    woken_out_d = woken_out_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d   = func_i;
          a_d      = {1'b0, thread_number_i};
          lq_d     = priority_level_i;
          end_d    = now_i + sleep_duration_i;
          now_d    = now_i;
          vis_d    = '1;
          chosen_d = NIL;
          woken_d  = '0;
          case (func_i)
            FN_READY:                     state_d = S_MR_RD;
            FN_PAUSE, FN_SLEEP, FN_DELETE: state_d = S_PA_RD;
            FN_SCHED:                     state_d = enable_q ? S_WK_RD : S_FIN;
            default:                      state_d = S_FIN;
          endcase
        end
      end
      S_MR_RD: begin
        state_d = S_MR_CK;
      end
      S_MR_CK: begin
        if (info_rd.memb != MEMB_NONE) begin
          state_d = S_FIN;
        end else begin
          info_we          = 1'b1;
          info_wdata       = info_rd;
          info_wdata.level = lq_q;
          info_wdata.memb  = MEMB_RUN;
          state_d          = S_APP;
        end
      end
      // Append thread a_q at the tail of level lq_q.
      S_APP: begin
        pv_we    = 1'b1;
        pv_wdata = tail_q[lq_q];
        nx_we    = 1'b1;
        nx_wdata = NIL;
        if (is_nil(tail_q[lq_q])) begin
          head_d[lq_q] = a_q;
        end
        tail_d[lq_q] = a_q;
        mask_d[lq_q] = 1'b1;
        prv_d        = tail_q[lq_q];
        state_d      = S_APP2;
      end
      S_APP2: begin
        if (!is_nil(prv_q)) begin
          nx_we    = 1'b1;
          nx_waddr = prv_q[THR_W-1:0];
          nx_wdata = a_q;
        end
        state_d = (func_q == FN_SCHED) ? S_WK_RD : S_FIN;
      end
      S_PA_RD: begin
        state_d = S_PA_CK;
      end
      S_PA_CK: begin
        rec_d   = info_rd;
        tn_d    = nx_rdata;
        tp_d    = pv_rdata;
        lq_d    = info_rd.level;
        state_d = (info_rd.memb == MEMB_RUN) ? S_PA_UL : S_PA_MK;
      end
      S_PA_UL: begin
        if (!is_nil(tp_q)) begin
          nx_we    = 1'b1;
          nx_waddr = tp_q[THR_W-1:0];
          nx_wdata = tn_q;
        end else begin
          head_d[lq_q] = tn_q;
        end
        if (!is_nil(tn_q)) begin
          pv_we    = 1'b1;
          pv_waddr = tn_q[THR_W-1:0];
          pv_wdata = tp_q;
        end else begin
          tail_d[lq_q] = tp_q;
        end
        info_we         = 1'b1;
        info_wdata.memb = MEMB_NONE;
        rec_d.memb      = MEMB_NONE;
        state_d         = S_PA_MK;
      end
      S_PA_MK: begin
        if (is_nil(head_q[lq_q])) begin
          mask_d[lq_q] = 1'b0;
        end
        case (func_q)
          FN_SLEEP, FN_DELETE: begin
            if (rec_q.memb == MEMB_SLEEP) begin
              state_d = S_SU;
            end else begin
              state_d = (func_q == FN_SLEEP) ? S_SW_ST : S_FIN;
            end
          end
          default: state_d = S_FIN;
        endcase
      end
      // Take thread a_q off the sleep list.
      S_SU: begin
        if (!is_nil(tp_q)) begin
          nx_we    = 1'b1;
          nx_waddr = tp_q[THR_W-1:0];
          nx_wdata = tn_q;
        end else begin
          shead_d = tn_q;
        end
        if (!is_nil(tn_q)) begin
          pv_we    = 1'b1;
          pv_waddr = tn_q[THR_W-1:0];
          pv_wdata = tp_q;
        end
        info_we         = 1'b1;
        info_wdata.memb = MEMB_NONE;
        rec_d.memb      = MEMB_NONE;
        state_d         = (func_q == FN_SLEEP) ? S_SW_ST : S_FIN;
      end
      S_SW_ST: begin
        cur_d   = shead_q;
        prv_d   = NIL;
        state_d = S_SW_RD;
      end
      // Walk past every sleeper whose wake time is not later than ours.
      S_SW_RD: begin
        raddr   = cur_q[THR_W-1:0];
        state_d = is_nil(cur_q) ? S_SW_IN : S_SW_CK;
      end
      S_SW_CK: begin
        if (info_rd.wake <= end_q) begin
          prv_d   = cur_q;
          cur_d   = nx_rdata;
          state_d = S_SW_RD;
        end else begin
          state_d = S_SW_IN;
        end
      end
      S_SW_IN: begin
        nx_we           = 1'b1;
        nx_wdata        = cur_q;
        pv_we           = 1'b1;
        pv_wdata        = prv_q;
        info_we         = 1'b1;
        info_wdata.wake = end_q;
        info_wdata.memb = MEMB_SLEEP;
        state_d         = S_SW_LK;
      end
      S_SW_LK: begin
        if (!is_nil(prv_q)) begin
          nx_we    = 1'b1;
          nx_waddr = prv_q[THR_W-1:0];
          nx_wdata = a_q;
        end else begin
          shead_d = a_q;
        end
        if (!is_nil(cur_q)) begin
          pv_we    = 1'b1;
          pv_waddr = cur_q[THR_W-1:0];
          pv_wdata = a_q;
        end
        state_d = S_FIN;
      end
      // Wake due sleepers from the head of the sleep list.
      S_WK_RD: begin
        raddr   = shead_q[THR_W-1:0];
        state_d = is_nil(shead_q) ? S_SC_PICK : S_WK_CK;
      end
      S_WK_CK: begin
        if (now_q >= info_rd.wake) begin
          a_d     = shead_q;
          shead_d = nx_rdata;
          if (!is_nil(nx_rdata)) begin
            pv_we    = 1'b1;
            pv_waddr = nx_rdata[THR_W-1:0];
            pv_wdata = NIL;
          end
          info_we         = 1'b1;
          info_waddr      = shead_q[THR_W-1:0];
          info_wdata      = info_rd;
          info_wdata.memb = MEMB_RUN;
          info_wdata.wake = '0;
          lq_d            = info_rd.level;
          woken_d         = woken_q + WOKEN_W'(1);
          state_d         = S_APP;
        end else begin
          state_d = S_SC_PICK;
        end
      end
      S_SC_PICK: begin
        if (cand == '0) begin
          state_d = S_SC_END;
        end else begin
          lq_d        = pick;
          vis_d[pick] = 1'b0;
          state_d     = S_SC_RD;
        end
      end
      S_SC_RD: begin
        raddr   = head_q[lq_q][THR_W-1:0];
        a_d     = head_q[lq_q];
        state_d = S_SC_CK;
      end
      // Count a span for the head; move it to the tail when others wait.
      S_SC_CK: begin
        info_we         = 1'b1;
        info_wdata      = info_rd;
        info_wdata.span = span_over ? '0 : span_inc[SPAN_W-1:0];
        if (!span_over) begin
          chosen_d = a_q;
        end
        if (!is_nil(nx_rdata)) begin
          head_d[lq_q] = nx_rdata;
          pv_we        = 1'b1;
          pv_waddr     = nx_rdata[THR_W-1:0];
          pv_wdata     = NIL;
          nx_we        = 1'b1;
          nx_waddr     = tail_q[lq_q][THR_W-1:0];
          nx_wdata     = a_q;
          state_d      = S_SC_RO;
        end else begin
          state_d = span_over ? S_SC_PICK : S_SC_END;
        end
      end
      S_SC_RO: begin
        pv_we        = 1'b1;
        pv_wdata     = tail_q[lq_q];
        nx_we        = 1'b1;
        nx_wdata     = NIL;
        tail_d[lq_q] = a_q;
        state_d      = is_nil(chosen_q) ? S_SC_PICK : S_SC_END;
      end
      S_SC_END: begin
        if (!is_nil(chosen_q) && !is_nil(running_q) && (running_q != chosen_q)) begin
          state_d = S_CL_RD;
        end else begin
          running_d = chosen_q;
          state_d   = S_FIN;
        end
      end
      S_CL_RD: begin
        raddr   = running_q[THR_W-1:0];
        state_d = S_CL_WR;
      end
      S_CL_WR: begin
        info_we         = 1'b1;
        info_waddr      = running_q[THR_W-1:0];
        info_wdata      = info_rd;
        info_wdata.span = '0;
        running_d       = chosen_q;
        state_d         = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          cur_out_d   = is_nil(running_q) ? '0 : running_q[THR_W-1:0];
          idle_d      = is_nil(running_q);
          sched_d     = (func_q == FN_SCHED) && enable_q;
          woken_out_d = woken_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      func_q      <= '0;
      end_q       <= '0;
      now_q       <= '0;
      a_q         <= NIL;
      lq_q        <= '0;
      rec_q       <= '0;
      tn_q        <= NIL;
      tp_q        <= NIL;
      cur_q       <= NIL;
      prv_q       <= NIL;
      chosen_q    <= NIL;
      running_q   <= NIL;
      shead_q     <= NIL;
      woken_q     <= '0;
      vis_q       <= '0;
      mask_q      <= '0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head_q[l] <= NIL;
        tail_q[l] <= NIL;
      end
      valid_q     <= '0;
      info_vld_q  <= 1'b0;
      enable_q    <= 1'b0;
      limit_q     <= SPAN_LIMIT_RST;
      out_valid_q <= 1'b0;
      cur_out_q   <= '0;
      idle_q      <= 1'b1;
      sched_q     <= 1'b0;
      woken_out_q <= '0;
    end else begin
      state_q     <= state_d;
      func_q      <= func_d;
      end_q       <= end_d;
      now_q       <= now_d;
      a_q         <= a_d;
      lq_q        <= lq_d;
      rec_q       <= rec_d;
      tn_q        <= tn_d;
      tp_q        <= tp_d;
      cur_q       <= cur_d;
      prv_q       <= prv_d;
      chosen_q    <= chosen_d;
      running_q   <= running_d;
      shead_q     <= shead_d;
      woken_q     <= woken_d;
      vis_q       <= vis_d;
      mask_q      <= mask_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      if (info_we) begin
        valid_q[info_waddr] <= 1'b1;
      end
      info_vld_q  <= valid_q[raddr];
      if (psel && penable && pwrite) begin
        if (paddr[2] == REG_LIMIT) begin
          limit_q <= pwdata[SPAN_W-1:0];
        end else begin
          enable_q <= pwdata[0];
        end
      end
      out_valid_q <= out_valid_d;
      cur_out_q   <= cur_out_d;
      idle_q      <= idle_d;
      sched_q     <= sched_d;
      woken_out_q <= woken_out_d;
    end
  end

  // The ready bitmap mirrors which run queues hold threads between items.
  `PRT_ASSERT(a_mask_tracks_queues, state_q == S_IDLE, mask_q == nonempty)
  // An accepted item always starts the sequencer.
  `PRT_ASSERT_NX(a_accept_starts, in_valid_i && in_ready_o, state_q != S_IDLE)
  // Rotation only happens on a queue that has a tail.
  `PRT_ASSERT(a_rotate_has_tail, state_q == S_SC_RO, !is_nil(tail_q[lq_q]))
  // No more sleepers can wake than there are threads.
  `PRT_ASSERT(a_woken_bounded, state_q == S_FIN, woken_q <= WOKEN_W'(MAX_THREADS))

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the multilevel priority round-robin thread scheduler.
// Depends on prt_pkg and the priority_round_robin_thread_scheduler top level.
module tb;
  import prt_pkg::*;

  typedef struct packed {
    logic [THR_W-1:0]   thr;
    logic               idle;
    logic               sched;
    logic [WOKEN_W-1:0] woken;
  } sched_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [FUNC_W-1:0] func_i = '0;
  logic [THR_W-1:0] thread_number_i = '0;
  logic [LVL_W-1:0] priority_level_i = '0;
  logic [TIME_W-1:0] sleep_duration_i = '0;
  logic [TIME_W-1:0] now_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [THR_W-1:0] active_thread_o;
  logic idle_o, scheduled_o;
  logic [WOKEN_W-1:0] woken_count_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  priority_round_robin_thread_scheduler dut (.*);

  // Clock with a period of 10 time units.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the scheduler state, kept in step with accepted items.
  ptr_t             link_nx[MAX_THREADS], link_pv[MAX_THREADS];
  ptr_t             lvl_head[NUM_LEVELS], lvl_tail[NUM_LEVELS];
  ptr_t             sleep_first, running;
  logic [LVL_W-1:0] lvl_of[MAX_THREADS];
  logic [2:0]       span_of[MAX_THREADS];
  logic [31:0]      wake_of[MAX_THREADS];
  memb_e            memb_of[MAX_THREADS];
  logic [31:0]      ready_bits;
  logic             sched_on;
  logic [2:0]       span_max;

  sched_res_t pending_results[$];
  int errors = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int n_sched = 0, n_items = 0;
  logic [31:0] uptime = 0;

  // Index of a thread pointer into the per-thread shadow arrays.
  function automatic logic [THR_W-1:0] ix(input ptr_t p);
    return p[THR_W-1:0];
  endfunction

  function automatic void queue_append(ptr_t t, int l);
    link_pv[ix(t)] = lvl_tail[l];
    link_nx[ix(t)] = NIL;
    if (!is_nil(lvl_tail[l])) link_nx[ix(lvl_tail[l])] = t;
    else lvl_head[l] = t;
    lvl_tail[l] = t;
  endfunction

  function automatic void queue_unlink(ptr_t t, int l);
    ptr_t p, n;
    p = link_pv[ix(t)];
    n = link_nx[ix(t)];
    if (!is_nil(p)) link_nx[ix(p)] = n; else lvl_head[l] = n;
    if (!is_nil(n)) link_pv[ix(n)] = p; else lvl_tail[l] = p;
    link_nx[ix(t)] = NIL;
    link_pv[ix(t)] = NIL;
  endfunction

  function automatic void sleeper_unlink(ptr_t t);
    ptr_t p, n;
    p = link_pv[ix(t)];
    n = link_nx[ix(t)];
    if (!is_nil(p)) link_nx[ix(p)] = n; else sleep_first = n;
    if (!is_nil(n)) link_pv[ix(n)] = p;
    link_nx[ix(t)] = NIL;
    link_pv[ix(t)] = NIL;
    memb_of[ix(t)] = MEMB_NONE;
  endfunction

  function automatic void enqueue_ready(ptr_t t, int l);
    if (memb_of[ix(t)] != MEMB_NONE) return;
    lvl_of[ix(t)] = LVL_W'(l);
    queue_append(t, l);
    memb_of[ix(t)] = MEMB_RUN;
    ready_bits[l] = 1'b1;
  endfunction

  function automatic void pause_thread(ptr_t t);
    int l;
    l = int'(lvl_of[ix(t)]);
    if (memb_of[ix(t)] == MEMB_RUN) begin
      queue_unlink(t, l);
      memb_of[ix(t)] = MEMB_NONE;
    end
    if (is_nil(lvl_head[l])) ready_bits[l] = 1'b0;
  endfunction

  // Applies one operation to the shadow state and returns the result it causes.
  function automatic sched_res_t apply_op(logic [2:0] f, logic [5:0] thr, logic [4:0] lv,
                                          logic [31:0] dur, logic [31:0] tnow);
    sched_res_t r;
    ptr_t t, cur, prv, h, chosen;
    logic [31:0] wake_at;
    logic [3:0] s;
    int woken, ran, g;
    t = ptr_t'(thr);
    woken = 0;
    ran = 0;
    chosen = NIL;
    case (f)
      FN_READY: enqueue_ready(t, int'(lv));
      FN_PAUSE: pause_thread(t);
      FN_SLEEP: begin
        wake_at = tnow + dur;
        pause_thread(t);
        if (memb_of[ix(t)] == MEMB_SLEEP) sleeper_unlink(t);
        // Walk past every sleeper due no later, so equal times keep their order.
        cur = sleep_first;
        prv = NIL;
        g = 0;
        while (!is_nil(cur) && g < MAX_THREADS && wake_of[ix(cur)] <= wake_at) begin
          prv = cur;
          cur = link_nx[ix(cur)];
          g++;
        end
        link_pv[ix(t)] = prv;
        link_nx[ix(t)] = cur;
        if (!is_nil(prv)) link_nx[ix(prv)] = t; else sleep_first = t;
        if (!is_nil(cur)) link_pv[ix(cur)] = t;
        wake_of[ix(t)] = wake_at;
        memb_of[ix(t)] = MEMB_SLEEP;
      end
      FN_DELETE: begin
        if (memb_of[ix(t)] == MEMB_SLEEP) sleeper_unlink(t);
        pause_thread(t);
      end
      FN_SCHED: if (sched_on) begin
        ran = 1;
        while (!is_nil(sleep_first) && tnow >= wake_of[ix(sleep_first)]) begin
          h = sleep_first;
          sleeper_unlink(h);
          enqueue_ready(h, int'(lvl_of[ix(h)]));
          wake_of[ix(h)] = 0;
          if (woken < 127) woken++;
        end
        if (ready_bits != 0) begin
          for (int i = 0; i < NUM_LEVELS; i++) begin
            h = lvl_head[i];
            if (is_nil(h)) continue;
            if (!is_nil(link_nx[ix(h)])) begin
              queue_unlink(h, i);
              queue_append(h, i);
            end
            s = {1'b0, span_of[ix(h)]} + 4'd1;
            if (s > {1'b0, span_max}) begin
              span_of[ix(h)] = 3'd0;
            end else begin
              span_of[ix(h)] = s[2:0];
              chosen = h;
              break;
            end
          end
        end
        if (!is_nil(chosen) && !is_nil(running) && running != chosen)
          span_of[ix(running)] = 3'd0;
        running = chosen;
      end
      default: ;
    endcase
    r.thr = is_nil(running) ? '0 : running[THR_W-1:0];
    r.idle = is_nil(running);
    r.sched = ran[0];
    r.woken = woken[WOKEN_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("tb: mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
    errors++;
  endtask

  // Receiver: random stalls according to the current idle percentage.
  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_idle_pct);

  // Result checker: every accepted result is matched against the oldest expectation.
  always @(posedge clk_i) begin
    sched_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result item", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (active_thread_o !== want.thr)
          report_mismatch("active_thread", active_thread_o, want.thr);
        if (idle_o !== want.idle) report_mismatch("idle", idle_o, want.idle);
        if (scheduled_o !== want.sched) report_mismatch("scheduled", scheduled_o, want.sched);
        if (woken_count_o !== want.woken)
          report_mismatch("woken_count", woken_count_o, want.woken);
      end
    end
  end

  // Watchdog: too many cycles in a row without any handshake ends the run.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Sends one item. Valid stays high across back-to-back items and is lowered
  // when the sender decides to idle before the next one or when results are drained.
  task automatic send_op(input logic [2:0] f, input logic [5:0] thr, input logic [4:0] lv,
                         input logic [31:0] dur, input logic [31:0] tnow);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    thread_number_i <= thr;
    priority_level_i <= lv;
    sleep_duration_i <= dur;
    now_i <= tnow;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(apply_op(f, thr, lv, dur, tnow));
    n_items++;
    if (f == FN_SCHED && sched_on) n_sched++;
  endtask

  // Lowers valid and holds off until every expected result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input int idx, input logic [31:0] val);
    drain_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * idx);
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_ENABLE) sched_on = val[0];
    else span_max = val[2:0];
  endtask

  task automatic reset_shadow();
    for (int i = 0; i < MAX_THREADS; i++) begin
      lvl_of[i] = '0;
      span_of[i] = '0;
      wake_of[i] = '0;
      link_nx[i] = NIL;
      link_pv[i] = NIL;
      memb_of[i] = MEMB_NONE;
    end
    for (int i = 0; i < NUM_LEVELS; i++) begin
      lvl_head[i] = NIL;
      lvl_tail[i] = NIL;
    end
    ready_bits = '0;
    sleep_first = NIL;
    running = NIL;
    sched_on = 1'b0;
    span_max = SPAN_LIMIT_RST;
  endtask

  // Directed cases: field extremes, every operation and the corner cases.
  task automatic test_directed();
    send_op(FN_SCHED, 0, 0, 0, 0);                 // disabled: nothing happens
    send_op(FN_READY, 6'd63, 5'd31, 0, 0);
    write_reg(REG_ENABLE, 1);
    send_op(FN_READY, 6'd0, 5'd0, 0, 0);
    send_op(FN_READY, 6'd5, 5'd31, 0, 0);
    send_op(FN_READY, 6'd0, 5'd7, 0, 0);           // already queued, ignored
    repeat (7) send_op(FN_SCHED, 0, 0, 0, 1);      // span limit forces a skip
    send_op(FN_PAUSE, 6'd9, 5'd0, 0, 0);           // not queued
    send_op(FN_PAUSE, 6'd0, 5'd0, 0, 0);
    send_op(FN_SLEEP, 6'd7, 5'd0, 32'hFFFF_FFFF, 32'hFFFF_FFF0); // wake time wraps
    send_op(FN_SLEEP, 6'd8, 5'd0, 32'hFFFF_FFEF, 32'd0);          // same wake time
    send_op(FN_SLEEP, 6'd7, 5'd0, 32'd3, 32'd10);  // sleeping thread reinserted
    send_op(FN_SCHED, 0, 0, 0, 32'hFFFF_FFFF);
    send_op(FN_DELETE, 6'd63, 5'd0, 0, 0);
    send_op(FN_DELETE, 6'd8, 5'd0, 0, 0);
    send_op(3'd5, 6'd1, 5'd1, 0, 0);
    send_op(3'd6, 6'd2, 5'd2, 0, 0);
    send_op(3'd7, 6'd3, 5'd3, 0, 0);
    write_reg(REG_LIMIT, 0);                       // every pick skipped
    send_op(FN_SCHED, 0, 0, 0, 32'hFFFF_FFFF);
    write_reg(REG_LIMIT, 5);
    send_op(FN_SCHED, 0, 0, 0, 32'hFFFF_FFFF);
  endtask

  // Random operations over a small thread pool so queues and the sleep list
  // stay busy, with occasional values across the whole field range.
  task automatic test_random(input int count, input int s_idle, input int r_idle);
    logic [2:0] f;
    logic [5:0] thr;
    logic [4:0] lv;
    logic [31:0] dur, tnow;
    int k;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      f = (k < 30) ? FN_READY : (k < 40) ? FN_PAUSE : (k < 55) ? FN_SLEEP :
          (k < 90) ? FN_SCHED : (k < 98) ? FN_DELETE : 3'($urandom_range(7, 5));
      thr = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(11));
      lv = ($urandom_range(4) == 0) ? 5'($urandom) : 5'($urandom_range(3));
      dur = ($urandom_range(19) == 0) ? $urandom : $urandom_range(24);
      uptime += $urandom_range(4);
      tnow = ($urandom_range(49) == 0) ? $urandom : uptime;
      send_op(f, thr, lv, dur, tnow);
      if (i == count / 2) drain_results();
    end
  endtask

  initial begin
    reset_shadow();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_reg(REG_LIMIT, 1);
    test_random(510, 35, 85);
    write_reg(REG_LIMIT, 7);
    test_random(510, 85, 35);
    write_reg(REG_LIMIT, $urandom_range(7, 2));
    test_random(250, 0, 0);
    write_reg(REG_ENABLE, 0);
    test_random(30, 0, 0);
    write_reg(REG_ENABLE, 1);
    test_random(230, 0, 0);
    drain_results();
    repeat (40) @(posedge clk_i);
    $display("tb: %0d items sent, %0d schedule passes run, span limits of zero and up used,",
             n_items, n_sched);
    $display("tb: sleepers, deletes, unknown codes and disabled scheduling exercised");
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
